// ----- rtl/ljenc_pkg.sv -----
// ============================================================================
// ljenc_pkg
// Shared constants, types and helper functions for the lossless JPEG
// entropy encoder (predictor 1, one Huffman table per component).
// ============================================================================
`default_nettype none

package ljenc_pkg;

    // Sizes of the coding problem.
    localparam int MAX_COMPONENTS  = 4;
    localparam int NUM_CATEGORIES  = 17;
    localparam int MAX_CODE_LENGTH = 16;
    localparam int TABLE_DEPTH     = MAX_COMPONENTS * NUM_CATEGORIES;
    localparam int TABLE_AW        = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W         = 21;

    // Request kinds carried in s_tuser.
    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_TABLE  = 2'd1;
    localparam logic [1:0] FUNC_FLUSH  = 2'd2;

    // Configuration register indexes (paddr[2]).
    localparam logic REG_LINE_WIDTH      = 1'b0;
    localparam logic REG_COMPONENT_COUNT = 1'b1;

    // Fixed values of the format.
    localparam logic [15:0] PRED_FRAME_START = 16'h8000;
    localparam logic [15:0] DIFF_MIN         = 16'h8000;
    localparam logic [7:0]  MARKER_BYTE      = 8'hFF;
    localparam logic [7:0]  STUFF_BYTE       = 8'h00;
    localparam logic [4:0]  CAT_MAX          = 5'd16;
    localparam logic [4:0]  CODE_LEN_MAX     = 5'd16;

    // Bits handed from the table lookup stage to the bit packer.
    typedef struct packed {
        logic [15:0] code;
        logic [4:0]  code_len;
        logic [15:0] extra;
        logic [4:0]  extra_len;
        logic        flush;
    } pack_req_t;

    // SSSS category of a 16-bit difference taken modulo 2^16.
    function automatic logic [4:0] category_of(input logic [15:0] d);
        logic [15:0] m;
        logic [4:0]  s;
        m = d[15] ? (~d + 16'd1) : d;
        s = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (m[i]) begin
                s = 5'(i + 1);
            end
        end
        if (d == DIFF_MIN) begin
            s = CAT_MAX;
        end
        return s;
    endfunction

    // Table address of a component and category: comp * 17 + sym.
    function automatic logic [TABLE_AW-1:0] tab_addr(input logic [1:0] comp,
                                                     input logic [4:0] sym);
        logic [TABLE_AW:0] a;
        a = {comp, 4'b0000} + {5'b00000, comp} + {2'b00, sym};
        return a[TABLE_AW-1:0];
    endfunction

    // Mask of the low len bits of a 16-bit word (len 16 gives all ones).
    function automatic logic [15:0] low_mask16(input logic [4:0] len);
        return ~(16'hFFFF << len);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ljenc_ram.sv -----
// ============================================================================
// ljenc_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when a read is enabled.
// ============================================================================
`default_nettype none

module ljenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ljenc_packer.sv -----
// ============================================================================
// ljenc_packer
// Bit packer and byte output stage: merges code and extra bits with the
// pending partial byte, emits whole bytes MSB first, and inserts a zero
// byte after every 0xFF.
// ============================================================================
`default_nettype none

module ljenc_packer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                req_valid,
    input  wire ljenc_pkg::pack_req_t req,
    output logic                     req_ready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,   // out_byte [7:0]
    output logic                     m_tlast
);

    // Pending partial byte.
    logic [6:0] pend_bits_reg;
    logic [2:0] pend_count_reg;

    // Byte group waiting on the output.
    logic       ob_valid_reg;
    logic [7:0] ob_bytes_reg [4];
    logic [2:0] ob_count_reg;
    logic [1:0] ob_idx_reg;
    logic       ob_stuff_reg;

    logic [3:0]  pad_len;
    logic [4:0]  x_len;
    logic [15:0] x_bits;
    logic [15:0] code_m;
    logic [15:0] x_m;
    logic [5:0]  sh_total;
    logic [5:0]  n_bits;
    logic [39:0] acc;
    logic [39:0] aligned;
    logic [2:0]  n_bytes;
    logic [6:0]  pend_bits_next;
    logic [7:0]  new_bytes [4];

    logic [7:0]  cur_byte;
    logic [1:0]  last_idx;
    logic        on_marker;
    logic        final_byte;
    logic        out_take;
    logic        req_take;

    // Merge the new bits below the pending ones and left-align the result.
    always_comb begin
        pad_len  = (pend_count_reg == 3'd0) ? 4'd0 : (4'd8 - {1'b0, pend_count_reg});
        x_len    = req.flush ? {1'b0, pad_len} : req.extra_len;
        x_bits   = req.flush ? 16'hFFFF : req.extra;
        code_m   = req.code & ljenc_pkg::low_mask16(req.code_len);
        x_m      = x_bits & ljenc_pkg::low_mask16(x_len);
        sh_total = {1'b0, req.code_len} + {1'b0, x_len};
        acc      = ({33'd0, pend_bits_reg} << sh_total)
                 | ({24'd0, code_m} << x_len)
                 | {24'd0, x_m};
        n_bits   = {3'b000, pend_count_reg} + sh_total;
        aligned  = acc << (6'd40 - n_bits);
        n_bytes  = n_bits[5:3];
        pend_bits_next = acc[6:0] & ~(7'h7F << n_bits[2:0]);
        for (int k = 0; k < 4; k++) begin
            new_bytes[k] = aligned[(39 - 8 * k) -: 8];
        end
    end

    // Output byte selection, stuffing and end-of-request detection.
    always_comb begin
        cur_byte   = ob_bytes_reg[ob_idx_reg];
        last_idx   = ob_count_reg[1:0] - 2'd1;
        on_marker  = !ob_stuff_reg && (cur_byte == ljenc_pkg::MARKER_BYTE);
        final_byte = (ob_idx_reg == last_idx) && !on_marker;
        m_tvalid   = ob_valid_reg;
        m_tdata    = ob_stuff_reg ? ljenc_pkg::STUFF_BYTE : cur_byte;
        m_tlast    = final_byte;
        out_take   = ob_valid_reg && m_tready;
        req_ready  = !ob_valid_reg || (out_take && final_byte);
        req_take   = req_valid && req_ready;
    end

    // Control state of the packer and the output stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg  <= 7'd0;
            pend_count_reg <= 3'd0;
            ob_valid_reg   <= 1'b0;
            ob_idx_reg     <= 2'd0;
            ob_stuff_reg   <= 1'b0;
            ob_count_reg   <= 3'd1;
        end else if (req_take) begin
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= n_bits[2:0];
            ob_valid_reg   <= (n_bytes != 3'd0);
            ob_idx_reg     <= 2'd0;
            ob_stuff_reg   <= 1'b0;
            ob_count_reg   <= n_bytes;
        end else if (out_take) begin
            if (on_marker) begin
                ob_stuff_reg <= 1'b1;
            end else if (final_byte) begin
                ob_valid_reg <= 1'b0;
            end else begin
                ob_idx_reg   <= ob_idx_reg + 2'd1;
                ob_stuff_reg <= 1'b0;
            end
        end
    end

    // Byte payload of a new group.
    always_ff @(posedge aclk) begin
        if (req_take) begin
            for (int k = 0; k < 4; k++) begin
                ob_bytes_reg[k] <= new_bytes[k];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lossless_jpeg_entropy_encoder.sv -----
// Path: an accepted request is registered in the lookup stage with its table
// read, then the packer registers its bytes as the output group on m_tdata.
// Throughput: one request per cycle while the output keeps up; a sample
// yields up to eight bytes with stuffing, and the packer takes no new request
// until the last byte of its group is taken, so the byte port sets the rate.
// Reset: synchronous, active low; code table contents are not cleared.
// ============================================================================
// lossless_jpeg_entropy_encoder
// Lossless JPEG predictor-1 difference coder with per-component Huffman
// tables, byte packing and zero stuffing after 0xFF.
// ============================================================================
`default_nettype none

module lossless_jpeg_entropy_encoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // sample_value [15:0], table_component [17:16], table_symbol [22:18],
    // table_code [38:23], table_length [43:39], zero [47:44]
    input  wire logic [47:0] s_tdata,
    input  wire logic [1:0]  s_tuser,   // func [1:0]
    // Output bytes
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // out_byte [7:0]
    output logic             m_tlast
);

    // Configuration registers.
    logic [15:0] line_width_reg;
    logic [2:0]  component_count_reg;

    // Scan position and prediction state.
    logic [15:0] left_reg       [ljenc_pkg::MAX_COMPONENTS];
    logic [15:0] line_first_reg [ljenc_pkg::MAX_COMPONENTS];
    logic [15:0] column_reg;
    logic [1:0]  comp_reg;
    logic        first_row_reg;

    // Lookup stage.
    logic        p1_valid_reg;
    logic [1:0]  p1_func_reg;
    logic [4:0]  p1_cat_reg;
    logic [15:0] p1_diff_reg;

    logic [1:0]  in_func;
    logic [15:0] in_sample;
    logic [1:0]  in_comp;
    logic [4:0]  in_sym;
    logic [15:0] in_code;
    logic [4:0]  in_len;
    logic        s_accept;

    logic [15:0] pred;
    logic [15:0] diff;
    logic [4:0]  cat;
    logic [2:0]  eff_count;
    logic [15:0] eff_width;
    logic [1:0]  comp_inc;
    logic [15:0] col_inc;
    logic        comp_wrap;
    logic        col_wrap;
    logic [1:0]  comp_next;
    logic [15:0] column_next;
    logic        first_row_next;

    logic                               tab_we;
    logic [ljenc_pkg::TABLE_AW-1:0]     tab_waddr;
    logic [ljenc_pkg::ENTRY_W-1:0]      tab_wdata;
    logic                               tab_re;
    logic [ljenc_pkg::TABLE_AW-1:0]     tab_raddr;
    logic [ljenc_pkg::ENTRY_W-1:0]      tab_rdata;

    ljenc_pkg::pack_req_t pk_req;
    logic                 pk_ready;
    logic [4:0]           ent_len;

    // Input field unpacking.
    assign in_func   = s_tuser;
    assign in_sample = s_tdata[15:0];
    assign in_comp   = s_tdata[17:16];
    assign in_sym    = s_tdata[22:18];
    assign in_code   = s_tdata[38:23];
    assign in_len    = s_tdata[43:39];

    assign s_tready = !p1_valid_reg || pk_ready;
    assign s_accept = s_tvalid && s_tready;

    // Register writes and reads.
    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            ljenc_pkg::REG_LINE_WIDTH:      prdata = {16'd0, line_width_reg};
            ljenc_pkg::REG_COMPONENT_COUNT: prdata = {29'd0, component_count_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg      <= 16'd1;
            component_count_reg <= 3'd1;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                ljenc_pkg::REG_LINE_WIDTH:      line_width_reg      <= pwdata[15:0];
                ljenc_pkg::REG_COMPONENT_COUNT: component_count_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Prediction, difference, category and the next scan position.
    always_comb begin
        if (column_reg == 16'd0) begin
            pred = first_row_reg ? ljenc_pkg::PRED_FRAME_START : line_first_reg[comp_reg];
        end else begin
            pred = left_reg[comp_reg];
        end
        diff = in_sample - pred;
        cat  = ljenc_pkg::category_of(diff);

        if (component_count_reg == 3'd0) begin
            eff_count = 3'd1;
        end else if (component_count_reg > 3'(ljenc_pkg::MAX_COMPONENTS)) begin
            eff_count = 3'(ljenc_pkg::MAX_COMPONENTS);
        end else begin
            eff_count = component_count_reg;
        end
        eff_width = (line_width_reg == 16'd0) ? 16'd1 : line_width_reg;

        comp_inc  = comp_reg + 2'd1;
        col_inc   = column_reg + 16'd1;
        comp_wrap = ({1'b0, comp_inc} >= eff_count) || (comp_inc == 2'd0);
        col_wrap  = (col_inc >= eff_width) || (col_inc == 16'd0);

        comp_next      = comp_reg;
        column_next    = column_reg;
        first_row_next = first_row_reg;
        case (in_func)
            ljenc_pkg::FUNC_SAMPLE: begin
                if (comp_wrap) begin
                    comp_next = 2'd0;
                    if (col_wrap) begin
                        column_next    = 16'd0;
                        first_row_next = 1'b0;
                    end else begin
                        column_next = col_inc;
                    end
                end else begin
                    comp_next = comp_inc;
                end
            end
            ljenc_pkg::FUNC_FLUSH: begin
                comp_next      = 2'd0;
                column_next    = 16'd0;
                first_row_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Scan position state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= 16'd0;
            comp_reg      <= 2'd0;
            first_row_reg <= 1'b1;
            for (int i = 0; i < ljenc_pkg::MAX_COMPONENTS; i++) begin
                left_reg[i]       <= 16'd0;
                line_first_reg[i] <= 16'd0;
            end
        end else if (s_accept) begin
            column_reg    <= column_next;
            comp_reg      <= comp_next;
            first_row_reg <= first_row_next;
            if (in_func == ljenc_pkg::FUNC_SAMPLE) begin
                left_reg[comp_reg] <= in_sample;
                if (column_reg == 16'd0) begin
                    line_first_reg[comp_reg] <= in_sample;
                end
            end
        end
    end

    // Lookup stage register, loaded alongside the table read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (pk_ready) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_func_reg <= in_func;
            p1_cat_reg  <= cat;
            p1_diff_reg <= diff;
        end
    end

    // Code table: written by table requests, read by sample requests.
    assign tab_we    = s_accept && (in_func == ljenc_pkg::FUNC_TABLE)
                     && (in_sym <= ljenc_pkg::CAT_MAX) && (in_len <= ljenc_pkg::CODE_LEN_MAX);
    assign tab_waddr = ljenc_pkg::tab_addr(in_comp, in_sym);
    assign tab_wdata = {in_len, in_code};
    assign tab_re    = s_accept && (in_func == ljenc_pkg::FUNC_SAMPLE);
    assign tab_raddr = ljenc_pkg::tab_addr(comp_reg, cat);

    ljenc_ram #(
        .WIDTH (ljenc_pkg::ENTRY_W),
        .DEPTH (ljenc_pkg::TABLE_DEPTH)
    ) u_code_table (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // Build the packer request from the looked-up code and the difference.
    always_comb begin
        ent_len = tab_rdata[20:16];
        if (ent_len > ljenc_pkg::CODE_LEN_MAX) begin
            ent_len = ljenc_pkg::CODE_LEN_MAX;
        end
        pk_req.code      = tab_rdata[15:0];
        pk_req.code_len  = 5'd0;
        pk_req.extra     = p1_diff_reg[15] ? (p1_diff_reg - 16'd1) : p1_diff_reg;
        pk_req.extra_len = 5'd0;
        pk_req.flush     = 1'b0;
        case (p1_func_reg)
            ljenc_pkg::FUNC_SAMPLE: begin
                pk_req.code_len = ent_len;
                if ((p1_cat_reg != 5'd0) && (p1_cat_reg != ljenc_pkg::CAT_MAX)) begin
                    pk_req.extra_len = p1_cat_reg;
                end
            end
            ljenc_pkg::FUNC_FLUSH: begin
                pk_req.flush = 1'b1;
            end
            default: ;
        endcase
    end

    ljenc_packer u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (p1_valid_reg),
        .req       (pk_req),
        .req_ready (pk_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
